/* hdl/pwm_fade_in_out_ramp_macros.svh */
// Assertion macros for the PWM fade ramp block.
// Used by the top level only; needs clk and rst_n in scope where expanded.
`ifndef PWM_FADE_IN_OUT_RAMP_MACROS_SVH
`define PWM_FADE_IN_OUT_RAMP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/pfr_pkg.sv */
// Shared types, constants and state encodings for the PWM fade ramp block.
// No dependencies; imported by every module of the block.
package pfr_pkg;

  // Field widths.
  localparam int TIME_W = 63;
  localparam int LVL_W  = 8;
  localparam int FADE_W = 32;
  localparam int PROD_W = LVL_W + FADE_W;
  localparam int CFG_IDX_W = 8;

  // Digit-serial subtractor geometry: 8-bit digits over a 64-bit word.
  localparam int DIG_W = 8;
  localparam int SER_W = TIME_W + 1;
  localparam int N_DIG = SER_W / DIG_W;
  localparam int E_DIG = FADE_W / DIG_W;
  localparam int CNT_W = $clog2(N_DIG);

  // Restoring divider: one quotient bit per step.
  localparam int DIV_CNT_W = $clog2(LVL_W);

  // Reset values of the fade lengths, in microseconds.
  localparam logic [FADE_W-1:0] FADE_IN_DEF  = 32'd1000000;
  localparam logic [FADE_W-1:0] FADE_OUT_DEF = 32'd1000000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT = 8'd1;

  typedef logic [TIME_W-1:0]    time_t;
  typedef logic [LVL_W-1:0]     lvl_t;
  typedef logic [FADE_W-1:0]    fade_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Fade phase of the ramp.
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_RISE = 3'd1,
    PH_ON   = 3'd2,
    PH_FALL = 3'd3,
    PH_OFF  = 3'd4
  } phase_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_SUB  = 3'd1,
    ST_MUL  = 3'd2,
    ST_DIV  = 3'd3,
    ST_DONE = 3'd4
  } state_t;

  // Result of the elapsed-time unit.
  typedef struct packed {
    logic  lt;
    fade_t elapsed;
  } sub_res_t;

endpackage

/* hdl/pfr_elapsed.sv */
// Digit-serial elapsed-time unit: computes now - start and compares it with the fade length.
// Depends on pfr_pkg.
module pfr_elapsed (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  pfr_pkg::time_t    now,
  input  pfr_pkg::time_t    start_time,
  input  pfr_pkg::fade_t    fade,
  output logic              done,
  output pfr_pkg::sub_res_t res
);
  import pfr_pkg::*;

  logic [SER_W-1:0] a_r, b_r, f_r;
  logic             bw1_r, bw2_r, fnz_r;
  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  fade_t            e_r;
  sub_res_t         res_r;
  logic [DIG_W:0]   d1, d2;
  logic             fnz_nxt;

  // Two chained digit subtractors: elapsed digit, then elapsed minus fade digit.
  always_comb begin
    d1 = {1'b0, a_r[DIG_W-1:0]} - {1'b0, b_r[DIG_W-1:0]} - (DIG_W+1)'(bw1_r);
    d2 = {1'b0, d1[DIG_W-1:0]} - {1'b0, f_r[DIG_W-1:0]} - (DIG_W+1)'(bw2_r);
    fnz_nxt = fnz_r | (|f_r[DIG_W-1:0]);
  end

  // Control: busy over all digits, done pulses after the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(N_DIG - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand shift registers, least significant digit first.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= {1'b0, now};
      b_r   <= {1'b0, start_time};
      f_r   <= {{(SER_W-FADE_W){1'b0}}, fade};
      bw1_r <= 1'b0;
      bw2_r <= 1'b0;
      fnz_r <= 1'b0;
    end else if (busy_r) begin
      a_r   <= a_r >> DIG_W;
      b_r   <= b_r >> DIG_W;
      f_r   <= f_r >> DIG_W;
      bw1_r <= d1[DIG_W];
      bw2_r <= d2[DIG_W];
      fnz_r <= fnz_nxt;
      // Only the low digits of the elapsed time are kept.
      if (cnt_r < CNT_W'(E_DIG)) begin
        e_r <= {d1[DIG_W-1:0], e_r[FADE_W-1:DIG_W]};
      end
      // A negative difference counts as zero elapsed time.
      if (cnt_r == CNT_W'(N_DIG - 1)) begin
        res_r.lt      <= d1[DIG_W] ? fnz_nxt : d2[DIG_W];
        res_r.elapsed <= d1[DIG_W] ? '0 : e_r;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

/* hdl/pfr_div.sv */
// Restoring divider, one quotient bit per cycle; the quotient must fit in LVL_W bits.
// Depends on pfr_pkg.
module pfr_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pfr_pkg::PROD_W-1:0]   num,
  input  pfr_pkg::fade_t               den,
  output logic                         done,
  output pfr_pkg::lvl_t                quo
);
  import pfr_pkg::*;

  fade_t                rem_r, den_r;
  lvl_t                 nlo_r, q_r;
  logic                 busy_r, done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [FADE_W:0]      trial, diff;
  logic                 ge;

  // One trial subtraction per step.
  always_comb begin
    trial = {rem_r, nlo_r[LVL_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = !diff[FADE_W];
  end

  // Step control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(LVL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers, most significant bit first.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[PROD_W-1:LVL_W];
      nlo_r <= num[LVL_W-1:0];
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[FADE_W-1:0] : trial[FADE_W-1:0];
      nlo_r <= {nlo_r[LVL_W-2:0], 1'b0};
      q_r   <= {q_r[LVL_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

/* hdl/pwm_fade_in_out_ramp.sv */
// PWM fade ramp top level: sequencer, state, configuration and output register.
// Outside a fade step an input goes straight to the output register; a fade step first
// runs the 8-digit elapsed-time subtractor and, below the fade length, the 8-step divider.
// A new input is taken only once the previous result has gone to the output register.
// Reset (synchronous, rst_n low): idle phase, no power, start time 0, fade lengths 1000000 us.
// Depends on pfr_pkg, pfr_elapsed, pfr_div and pwm_fade_in_out_ramp_macros.svh.
`include "pwm_fade_in_out_ramp_macros.svh"

module pwm_fade_in_out_ramp #(
  parameter pfr_pkg::fade_t FADE_IN_RESET  = pfr_pkg::FADE_IN_DEF,
  parameter pfr_pkg::fade_t FADE_OUT_RESET = pfr_pkg::FADE_OUT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pfr_pkg::time_t    in_time_now,
  input  pfr_pkg::lvl_t     in_level,
  input  logic              in_power_on,
  output logic              out_valid,
  input  logic              out_ready,
  output pfr_pkg::lvl_t     out_duty,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  pfr_pkg::cfg_idx_t cfg_index,
  input  pfr_pkg::fade_t    cfg_data
);
  import pfr_pkg::*;

  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic                prev_power_r, prev_nxt;
  time_t               start_time_r, start_nxt;
  fade_t               rise_len_r, fall_len_r, fade_sel;
  lvl_t                lvl_r, duty_r, duty_nxt, out_duty_r;
  logic [PROD_W-1:0]   prod_r;
  logic                out_valid_r;
  logic                fade_step, out_free, in_take;
  logic                sub_start, sub_done, div_start, div_done, out_load;
  sub_res_t            sub_res;
  lvl_t                div_q;

  // Shared decodes.
  assign fade_step = (in_power_on == prev_power_r) &&
                     (phase_r == PH_RISE || phase_r == PH_FALL);
  assign out_free  = !out_valid_r || out_ready;
  assign fade_sel  = (phase_r == PH_RISE) ? rise_len_r : fall_len_r;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = fade_step ? ST_SUB : ST_DONE;
      ST_SUB:  if (sub_done) state_nxt = sub_res.lt ? ST_MUL : ST_DONE;
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: in_ready  = 1'b1;
      ST_MUL:  div_start = 1'b1;
      ST_DONE: out_load  = out_free;
      default: ;
    endcase
  end

  assign in_take   = in_valid && in_ready;
  assign sub_start = in_take && fade_step;

  // Phase, edge tracking and duty selection.
  always_comb begin
    phase_nxt = phase_r;
    prev_nxt  = prev_power_r;
    start_nxt = start_time_r;
    duty_nxt  = duty_r;
    if (in_take) begin
      prev_nxt = in_power_on;
      if (in_power_on != prev_power_r) begin
        start_nxt = in_time_now;
        if (in_power_on) begin
          phase_nxt = PH_RISE;
          duty_nxt  = '0;
        end else begin
          phase_nxt = PH_FALL;
          duty_nxt  = in_level;
        end
      end else begin
        case (phase_r)
          PH_ON:   duty_nxt = in_level;
          default: duty_nxt = '0;
        endcase
      end
    end else if (state_r == ST_SUB && sub_done && !sub_res.lt) begin
      // Fade length reached: settle into the steady phase.
      if (phase_r == PH_RISE) begin
        phase_nxt = PH_ON;
        duty_nxt  = lvl_r;
      end else begin
        phase_nxt = PH_OFF;
        duty_nxt  = '0;
      end
    end else if (state_r == ST_DIV && div_done) begin
      duty_nxt = (phase_r == PH_RISE) ? div_q : lvl_r - div_q;
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= PH_IDLE;
      prev_power_r <= 1'b0;
      start_time_r <= '0;
      rise_len_r   <= FADE_IN_RESET;
      fall_len_r   <= FADE_OUT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      prev_power_r <= prev_nxt;
      start_time_r <= start_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FADE_IN:  rise_len_r <= cfg_data;
          CFG_FADE_OUT: fall_len_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    duty_r <= duty_nxt;
    if (in_take) begin
      lvl_r <= in_level;
    end
    if (state_r == ST_SUB && sub_done) begin
      prod_r <= PROD_W'(lvl_r) * PROD_W'(sub_res.elapsed);
    end
    if (out_load) begin
      out_duty_r <= duty_r;
    end
  end

  // Elapsed time and comparison against the active fade length.
  pfr_elapsed u_elapsed (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (sub_start),
    .now        (in_time_now),
    .start_time (start_time_r),
    .fade       (fade_sel),
    .done       (sub_done),
    .res        (sub_res)
  );

  // level * elapsed / fade.
  pfr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r),
    .den   (fade_sel),
    .done  (div_done),
    .quo   (div_q)
  );

  assign out_valid = out_valid_r;
  assign out_duty  = out_duty_r;
  assign cfg_ready = 1'b1;

  // Checks on the sequencer and its units.
  `PFR_ASSERT_NOW(a_sub_done_state, sub_done, state_r == ST_SUB, "elapsed unit done outside SUB")
  `PFR_ASSERT_NOW(a_div_done_state, div_done, state_r == ST_DIV, "divider done outside DIV")
  `PFR_ASSERT_NOW(a_sub_in_fade, sub_start, phase_r == PH_RISE || phase_r == PH_FALL, "no fade")
  `PFR_ASSERT_NEXT(a_edge_direct, in_take && (in_power_on != prev_power_r), state_r == ST_DONE, "edge not direct")

endmodule
